// ===== hdl/rme_pkg.sv =====
`timescale 1ns / 1ps

package rme_pkg;

  // Default width of the modular datapath.
  localparam int DEFAULT_MOD_WIDTH = 32;

  // Field widths of the channels and the configuration port.
  localparam int CHAR_W      = 8;
  localparam int CIPHER_W    = 32;
  localparam int EXP_W       = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS         = 2'd1;

  // Register values after reset.
  localparam logic [EXP_W-1:0]      RESET_PUBLIC_EXPONENT = 32'd65537;
  localparam logic [CFG_DATA_W-1:0] RESET_MODULUS         = 32'd3233;

endpackage

// ===== hdl/rme_char_if.sv =====
`timescale 1ns / 1ps

interface rme_char_if;
  import rme_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_in;

  modport source (output valid, output char_code, output last_in, input ready);
  modport sink   (input valid, input char_code, input last_in, output ready);

endinterface

// ===== hdl/rme_cipher_if.sv =====
`timescale 1ns / 1ps

interface rme_cipher_if;
  import rme_pkg::*;

  logic                valid;
  logic                ready;
  logic [CIPHER_W-1:0] cipher_value;
  logic                last_out;

  modport source (output valid, output cipher_value, output last_out, input ready);
  modport sink   (input valid, input cipher_value, input last_out, output ready);

endinterface

// ===== hdl/rme_mulmod.sv =====
`timescale 1ns / 1ps

// Bit-serial modular multiplier: p = (a * b) mod m for a, b < m.
// The multiplier b is shifted out MSB first; each bit has a modular doubling
// step followed by a conditional modular add step.
module rme_mulmod #(
  parameter int MW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  input  logic [MW-1:0] m,
  output logic [MW-1:0] p,
  output logic          busy,
  output logic          done
);

  localparam int CW = $clog2(MW);

  logic [MW-1:0] acc;
  logic [MW-1:0] bsh;
  logic [CW-1:0] cnt;
  logic          phase;

  logic [MW:0] dbl;
  logic [MW:0] dbl_red;
  logic [MW:0] sum;
  logic [MW:0] sum_red;

  // Modular doubling and modular addition, each one add and one compare.
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = {1'b0, acc} + {1'b0, a};
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && phase && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: accumulator, multiplier shift register and bit counter.
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      bsh   <= b;
      cnt   <= CW'(MW - 1);
      phase <= 1'b0;
    end else if (busy) begin
      if (!phase) begin
        acc   <= dbl_red[MW-1:0];
        phase <= 1'b1;
      end else begin
        if (bsh[MW-1]) begin
          acc <= sum_red[MW-1:0];
        end
        bsh   <= bsh << 1;
        cnt   <= cnt - 1'b1;
        phase <= 1'b0;
      end
    end
  end

  assign p = acc;

  // A finished product never coincides with a running one.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("mulmod signals done while still busy");

  // A start always leads to a busy unit.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("mulmod did not go busy after start");

  // The result stays below the modulus when a product completes.
  a_done_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (p < m))
    else $error("mulmod product not reduced");

endmodule

// ===== hdl/rsa_modular_exponentiation.sv =====
`timescale 1ns / 1ps

// RSA modular exponentiation: cipher_value = char_code ^ public_exponent mod modulus.
// Items enter on char_in (char_code, last_in) and leave on cipher_out
// (cipher_value, last_out); last_out is a copy of last_in. Both channels use
// valid/ready and move an item on a clock edge where both are high.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle; the block itself does not enforce this. Index 0 is
// the public exponent, index 1 the modulus. One item is processed at a time.
// The base is first reduced modulo the modulus, then one square-and-multiply
// round runs for each exponent bit up to the highest set one. Each round uses
// two bit-serial modular multipliers side by side (product and square).
// A zero exponent or a modulus below two skips the reduction and the rounds.
// The result sits in an output register, so a new item is taken while a
// result waits; a finished item holds in the block until cipher_out frees.
// Synchronous reset clears the control state and restores the registers
// to exponent 65537 and modulus 3233.
module rsa_modular_exponentiation #(
  parameter int MOD_WIDTH = rme_pkg::DEFAULT_MOD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rme_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rme_pkg::CFG_DATA_W-1:0]   cfg_data,
  rme_char_if.sink                         char_in,
  rme_cipher_if.source                     cipher_out
);
  import rme_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RED   = 5'b00010,
    S_START = 5'b00100,
    S_MUL   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state;

  logic [EXP_W-1:0]     public_exponent;
  logic [MOD_WIDTH-1:0] modulus;

  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] base;
  logic [EXP_W-1:0]     e_sh;
  logic [CHAR_W-1:0]    code_sh;
  logic [2:0]           rcnt;
  logic                 last_reg;

  logic                 mod_ok;
  logic                 accept;
  logic                 out_free;
  logic                 mul_start;
  logic [MOD_WIDTH-1:0] p_acc;
  logic [MOD_WIDTH-1:0] p_sq;
  logic                 busy_acc;
  logic                 busy_sq;
  logic                 done_acc;
  logic                 done_sq;
  logic [MOD_WIDTH:0]   red_t;
  logic [MOD_WIDTH:0]   red_next;

  assign mod_ok    = (modulus[MOD_WIDTH-1:1] != '0);
  assign accept    = char_in.valid && char_in.ready;
  assign out_free  = !cipher_out.valid || cipher_out.ready;
  assign mul_start = (state == S_START);
  assign char_in.ready = (state == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent <= RESET_PUBLIC_EXPONENT;
      modulus         <= MOD_WIDTH'(RESET_MODULUS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PUBLIC_EXPONENT: public_exponent <= cfg_data;
        REG_MODULUS:         modulus         <= MOD_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // Base reduction, one character bit per cycle, MSB first.
  always_comb begin
    red_t    = {base, code_sh[CHAR_W-1]};
    red_next = (red_t >= {1'b0, modulus}) ? red_t - {1'b0, modulus} : red_t;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!mod_ok || public_exponent == '0) begin
              state <= S_HOLD;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (rcnt == '0) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (done_acc) begin
            state <= (e_sh[EXP_W-1:1] == '0) ? S_HOLD : S_START;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the exponentiation.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          acc      <= mod_ok ? MOD_WIDTH'(1) : '0;
          base     <= '0;
          e_sh     <= public_exponent;
          code_sh  <= char_in.char_code;
          rcnt     <= 3'd7;
          last_reg <= char_in.last_in;
        end
      end
      S_RED: begin
        base    <= red_next[MOD_WIDTH-1:0];
        code_sh <= code_sh << 1;
        rcnt    <= rcnt - 1'b1;
      end
      S_MUL: begin
        if (done_acc) begin
          if (e_sh[0]) begin
            acc <= p_acc;
          end
          base <= p_sq;
          e_sh <= e_sh >> 1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_out.valid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      cipher_out.valid <= 1'b1;
    end else if (cipher_out.ready) begin
      cipher_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      cipher_out.cipher_value <= CIPHER_W'(acc);
      cipher_out.last_out     <= last_reg;
    end
  end

  // Product of accumulator and base.
  rme_mulmod #(.MW(MOD_WIDTH)) u_mul_acc (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (acc),
    .b     (base),
    .m     (modulus),
    .p     (p_acc),
    .busy  (busy_acc),
    .done  (done_acc)
  );

  // Square of the base.
  rme_mulmod #(.MW(MOD_WIDTH)) u_mul_sq (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (base),
    .b     (base),
    .m     (modulus),
    .p     (p_sq),
    .busy  (busy_sq),
    .done  (done_sq)
  );

  // The two multipliers run in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (done_acc == done_sq) && (busy_acc == busy_sq))
    else $error("multipliers out of step");

  // The multipliers only work while the sequencer waits on them.
  a_busy_in_mul: assert property (@(posedge clk) disable iff (rst)
    busy_acc |-> (state == S_MUL))
    else $error("multiplier busy outside the multiply state");

  // An accepted item always starts work.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start");

  // A delivered value is always reduced below the modulus.
  a_out_reduced: assert property (@(posedge clk) disable iff (rst)
    (cipher_out.valid && mod_ok) |->
      (MOD_WIDTH'(cipher_out.cipher_value) < modulus))
    else $error("result not reduced");

endmodule

// ===== dv/rsa_modular_exponentiation_test.sv =====
`timescale 1ns / 1ps

module rsa_modular_exponentiation_test;
  import rme_pkg::*;

  localparam int MOD_W          = DEFAULT_MOD_WIDTH;
  localparam int RANDOM_PHASES  = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2200;
  localparam int MAX_REPORTS    = 10;

  // Register indexes that the block does not decode.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  typedef struct packed {
    logic [CIPHER_W-1:0] value;
    logic                last;
  } cipher_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rme_char_if   char_in ();
  rme_cipher_if cipher_out ();

  rsa_modular_exponentiation #(
    .MOD_WIDTH(MOD_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_in   (char_in),
    .cipher_out(cipher_out)
  );

  // Characters waiting to be sent and ciphertexts waiting to come back.
  char_item_t       pending_chars[$];
  cipher_item_t     expected_ciphers[$];

  // Local copy of the configuration registers.
  logic [EXP_W-1:0] exponent_reg = RESET_PUBLIC_EXPONENT;
  logic [MOD_W-1:0] modulus_reg  = RESET_MODULUS[MOD_W-1:0];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square-and-multiply with exact 64-bit products.
  function automatic logic [CIPHER_W-1:0] rsa_power(input logic [CHAR_W-1:0] code,
                                                    input logic [EXP_W-1:0] exponent,
                                                    input logic [MOD_W-1:0] modulus);
    logic [63:0]      acc;
    logic [63:0]      base;
    logic [63:0]      m;
    logic [EXP_W-1:0] rest;
    if (modulus < 2) begin
      return '0;
    end
    m    = 64'(modulus);
    acc  = 64'd1;
    base = 64'(code) % m;
    rest = exponent;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = (acc * base) % m;
      end
      base = (base * base) % m;
      rest = rest >> 1;
    end
    return acc[CIPHER_W-1:0];
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("Mismatch: %s", msg);
    end
    mismatch_count++;
  endtask

  task automatic queue_char(input logic [CHAR_W-1:0] code, input logic last);
    pending_chars.push_back('{code: code, last: last});
  endtask

  // Mostly whole words with the mark on the final character, some stray marks.
  task automatic queue_words(input int n);
    int left;
    logic last;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(8, 1);
      end
      left--;
      last = (left == 0);
      if ($urandom_range(7) == 0) begin
        last = 1'($urandom_range(1));
      end
      queue_char(CHAR_W'($urandom_range(255)), last);
    end
  endtask

  // Wait at falling edges until every item has gone in and come back.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_chars.size() != 0 || expected_ciphers.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_PUBLIC_EXPONENT: exponent_reg = value;
      REG_MODULUS:         modulus_reg = value[MOD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [EXP_W-1:0] exponent,
                            input logic [CFG_DATA_W-1:0] modulus);
    write_reg(REG_PUBLIC_EXPONENT, exponent);
    write_reg(REG_MODULUS, modulus);
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 74;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 74;
      end
      IDLE_BOTH: begin
        send_idle_pct = 29;
        stall_pct     = 29;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  // Character driver: predicts the ciphertext of each item as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      char_in.valid     <= 1'b0;
      char_in.char_code <= '0;
      char_in.last_in   <= 1'b0;
    end else begin
      if (char_in.valid && char_in.ready) begin
        expected_ciphers.push_back('{
          value: rsa_power(char_in.char_code, exponent_reg, modulus_reg),
          last:  char_in.last_in});
        void'(pending_chars.pop_front());
      end
      if (!char_in.valid || char_in.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_in.valid     <= 1'b1;
          char_in.char_code <= pending_chars[0].code;
          char_in.last_in   <= pending_chars[0].last;
        end else begin
          char_in.valid <= 1'b0;
        end
      end
    end
  end

  // Ciphertext monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin : cipher_monitor
    cipher_item_t want;
    if (rst) begin
      cipher_out.ready <= 1'b0;
    end else begin
      if (cipher_out.valid && cipher_out.ready) begin
        if (expected_ciphers.size() == 0) begin
          note_mismatch($sformatf("unexpected item, cipher_value %0d last_out %0b",
                                  cipher_out.cipher_value, cipher_out.last_out));
        end else begin
          want = expected_ciphers.pop_front();
          if (cipher_out.cipher_value !== want.value) begin
            note_mismatch($sformatf("cipher_value expected %0d, actual %0d",
                                    want.value, cipher_out.cipher_value));
          end
          if (cipher_out.last_out !== want.last) begin
            note_mismatch($sformatf("last_out expected %0b, actual %0b",
                                    want.last, cipher_out.last_out));
          end
        end
      end
      cipher_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (char_in.valid && char_in.ready) || (cipher_out.valid && cipher_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                    count;
    int                    nbits;
    logic [EXP_W-1:0]      exponent;
    logic [CFG_DATA_W-1:0] modulus;

    set_idle(IDLE_NONE);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Values after reset, with the character extremes.
    @(negedge clk);
    queue_char(8'd0, 1'b0);
    queue_char(8'd255, 1'b1);
    queue_char(8'd1, 1'b0);
    queue_char(8'd65, 1'b1);
    drain();

    // Writes to undecoded indexes must leave both registers alone.
    write_reg(REG_SPARE_LOW, '0);
    write_reg(REG_SPARE_HIGH, '1);
    @(negedge clk);
    queue_char(8'd2, 1'b0);
    queue_char(8'd200, 1'b1);
    drain();

    // A zero exponent gives one, even for a zero character.
    set_config('0, '1);
    queue_char(8'd0, 1'b1);
    queue_char(8'd255, 1'b0);
    drain();

    // Largest exponent and modulus.
    set_config('1, '1);
    queue_char(8'd255, 1'b0);
    queue_char(8'd2, 1'b1);
    drain();

    // A modulus below two gives zero.
    set_config(32'd5, 32'd0);
    queue_char(8'd7, 1'b0);
    queue_char(8'd255, 1'b1);
    drain();
    set_config(32'd5, 32'd1);
    queue_char(8'd7, 1'b1);
    queue_char(8'd255, 1'b0);
    drain();

    // Smallest legal modulus, then a modulus just above the largest character.
    set_config(32'h1234_5679, 32'd2);
    queue_char(8'd0, 1'b0);
    queue_char(8'd1, 1'b0);
    queue_char(8'd255, 1'b1);
    drain();
    set_config(32'd1, 32'd256);
    queue_char(8'd255, 1'b0);
    queue_char(8'd128, 1'b1);
    drain();

    // Random settings; most exponents are short, a few use all 32 bits.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idle(idle_mode_t'(p % 4));
      if (p % 5 == 4) begin
        exponent = $urandom() | 32'h8000_0000;
        count    = 10;
      end else begin
        nbits    = $urandom_range(12, 1);
        exponent = ($urandom() & ((32'd1 << nbits) - 32'd1)) | (32'd1 << (nbits - 1));
        if ($urandom_range(9) == 0) begin
          exponent = '0;
        end
        count = 20;
      end
      case ($urandom_range(7))
        0:       modulus = $urandom_range(300, 2);
        1, 2:    modulus = $urandom_range(65535, 2);
        3, 4, 5: modulus = $urandom();
        6:       modulus = 32'hFFFF_FFFF - $urandom_range(15);
        default: modulus = $urandom_range(1, 0);
      endcase
      set_config(exponent, modulus);
      if (p == 6) begin
        // Hold back the second half until the block has emptied.
        queue_words(count / 2);
        drain();
        queue_words(count - count / 2);
      end else begin
        queue_words(count);
      end
      drain();
    end

    // Keep the output open long enough to catch any stray item.
    set_idle(IDLE_NONE);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_ciphers.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", expected_ciphers.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
